[rtl/trle_pkg.sv]
package trle_pkg;

    localparam int VALUE_W    = 32;
    localparam int THR_W      = 31;
    localparam int TOT_W      = 17;
    localparam int KIND_W     = 2;
    localparam int M_TDATA_W  = 72;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLAG  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] data;
        logic [TOT_W-1:0]   kept_total;
        logic [TOT_W-1:0]   runs_total;
        logic               eov;
    } result_t;

    // Up to three results per element, in output order: flag or closed run,
    // kept value, flushed run.
    typedef struct packed {
        logic [2:0]    vld;
        result_t [2:0] res;
    } push_t;

endpackage

[rtl/trle_encode.sv]
module trle_encode #(
    parameter int MAX_LEN = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [trle_pkg::THR_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [trle_pkg::VALUE_W-1:0]     s_tdata,
    input  logic                             s_tlast,
    input  logic                             space_ok,
    output trle_pkg::push_t                  push
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    logic [trle_pkg::THR_W-1:0]   thr_reg;
    logic                         in_vld_reg;
    logic [trle_pkg::VALUE_W-1:0] in_value_reg;
    logic                         in_last_reg;

    logic             at_start_reg, at_start_next;
    logic             run_kept_reg, run_kept_next;
    logic [CNT_W-1:0] run_len_reg,  run_len_next;
    logic [CNT_W-1:0] kept_reg,     kept_next;
    logic [CNT_W-1:0] runs_reg,     runs_next;

    logic                         advance;
    logic [trle_pkg::VALUE_W-1:0] mag;
    logic                         keep;
    trle_pkg::push_t              res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x >= MAX_CNT) ? MAX_CNT : x + 1'b1;
    endfunction

    assign advance  = in_vld_reg && space_ok;
    assign s_tready = !in_vld_reg || advance;

    // The most negative value negates to itself, which reads as 2^31 unsigned.
    assign mag  = in_value_reg[trle_pkg::VALUE_W-1] ? (~in_value_reg + 1'b1) : in_value_reg;
    assign keep = mag >= {1'b0, thr_reg};

    always_comb begin
        at_start_next = at_start_reg;
        run_kept_next = run_kept_reg;
        run_len_next  = run_len_reg;
        kept_next     = kept_reg;
        runs_next     = runs_reg;
        res           = '0;

        if (at_start_reg) begin
            res.vld[0]        = 1'b1;
            res.res[0].kind   = trle_pkg::KIND_FLAG;
            res.res[0].data   = trle_pkg::VALUE_W'(keep);
            at_start_next     = 1'b0;
            run_kept_next     = keep;
            run_len_next      = CNT_W'(1);
            kept_next         = '0;
            runs_next         = '0;
        end else if (keep == run_kept_reg) begin
            run_len_next = sat_inc(run_len_reg);
        end else begin
            res.vld[0]      = 1'b1;
            res.res[0].kind = trle_pkg::KIND_RUN;
            res.res[0].data = trle_pkg::VALUE_W'(run_len_reg);
            runs_next       = sat_inc(runs_reg);
            run_kept_next   = keep;
            run_len_next    = CNT_W'(1);
        end

        if (keep) begin
            res.vld[1]      = 1'b1;
            res.res[1].kind = trle_pkg::KIND_VALUE;
            res.res[1].data = in_value_reg;
            kept_next       = sat_inc(kept_next);
        end

        if (in_last_reg) begin
            runs_next             = sat_inc(runs_next);
            res.vld[2]            = 1'b1;
            res.res[2].kind       = trle_pkg::KIND_RUN;
            res.res[2].data       = trle_pkg::VALUE_W'(run_len_next);
            res.res[2].kept_total = trle_pkg::TOT_W'(kept_next);
            res.res[2].runs_total = trle_pkg::TOT_W'(runs_next);
            res.res[2].eov        = 1'b1;
            at_start_next         = 1'b1;
            run_kept_next         = 1'b0;
            run_len_next          = '0;
            kept_next             = '0;
            runs_next             = '0;
        end

        push     = res;
        push.vld = advance ? res.vld : 3'b000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= '0;
            in_vld_reg   <= 1'b0;
            at_start_reg <= 1'b1;
            run_kept_reg <= 1'b0;
            run_len_reg  <= '0;
            kept_reg     <= '0;
            runs_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                at_start_reg <= at_start_next;
                run_kept_reg <= run_kept_next;
                run_len_reg  <= run_len_next;
                kept_reg     <= kept_next;
                runs_reg     <= runs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_value_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> at_start_reg && kept_reg == '0 && runs_reg == '0)
        else $error("vector did not return to start after last element");

    a_counters_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        run_len_reg <= MAX_CNT && kept_reg <= MAX_CNT && runs_reg <= MAX_CNT)
        else $error("counter passed saturation limit");

    a_flag_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld[0] && push.res[0].kind == trle_pkg::KIND_FLAG |-> at_start_reg)
        else $error("flag emitted outside vector start");

endmodule

[rtl/trle_outq.sv]
module trle_outq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  trle_pkg::push_t               push,
    output logic                          space_ok,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output trle_pkg::result_t             head
);

    trle_pkg::result_t entries [trle_pkg::QDEPTH];

    logic [trle_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [trle_pkg::QCNT_W-1:0] count_reg;
    logic [trle_pkg::QPTR_W-1:0] idx [3];
    logic [trle_pkg::QCNT_W-1:0] npush;
    logic                        pop;

    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = entries[rd_ptr_reg];
    // Room for a full three-result element, decided from registered state only.
    assign space_ok = count_reg <= trle_pkg::QCNT_W'(trle_pkg::QDEPTH - 3);

    always_comb begin
        idx[0] = wr_ptr_reg;
        idx[1] = idx[0] + trle_pkg::QPTR_W'(push.vld[0]);
        idx[2] = idx[1] + trle_pkg::QPTR_W'(push.vld[1]);
        npush  = trle_pkg::QCNT_W'(push.vld[0]) + trle_pkg::QCNT_W'(push.vld[1])
               + trle_pkg::QCNT_W'(push.vld[2]);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (push.vld[i]) begin
                entries[idx[i]] <= push.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + trle_pkg::QPTR_W'(npush);
            rd_ptr_reg <= rd_ptr_reg + trle_pkg::QPTR_W'(pop);
            count_reg  <= count_reg + npush - trle_pkg::QCNT_W'(pop);
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= trle_pkg::QCNT_W'(trle_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld != 3'b000 |-> space_ok)
        else $error("results pushed without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + $past(npush) - trle_pkg::QCNT_W'($past(pop)))
        else $error("queue occupancy mismatch");

endmodule

[rtl/threshold_run_length_encoder.sv]
// Flow: an element beat is registered at acceptance in the input register; its results are
// then written into the result queue, whose head is presented as the first result on m_.
// Throughput: one element per cycle while each element yields at most one result and
// m_tready is high; the single result port moves one beat per cycle, so more results slow intake.
// Reset: aresetn is synchronous, active low; it clears the threshold to 0, empties the
// result queue and returns the encoder to the vector-start condition.
module threshold_run_length_encoder #(
    parameter int MAX_LEN = 65536
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Threshold register write port; applies from the next element on.
    input  logic                              cfg_wr_en,
    input  logic [trle_pkg::THR_W-1:0]        cfg_wr_data,
    // Element input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [trle_pkg::VALUE_W-1:0]      s_tdata,    // [31:0] value
    input  logic                              s_tlast,    // last element of the vector
    // Result output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [trle_pkg::M_TDATA_W-1:0]    m_tdata,    // [31:0] data, [48:32] kept_total,
                                                          // [65:49] runs_total, [71:66] zero
    output logic [trle_pkg::KIND_W-1:0]       m_tuser,    // [1:0] kind
    output logic                              m_tlast     // end_of_vector
);

    // The encoder holds one element in its input register and, in the same cycle
    // that it leaves, writes all of its results (at most three) into a four-entry
    // result queue. The encoder advances only when the queue holds at most one
    // beat, a decision made from registered occupancy, so m_tready never reaches
    // s_tready combinationally. With one result per element and m_tready high, the queue
    // settles at one entry and the block takes an element every cycle.

    trle_pkg::push_t   push;
    trle_pkg::result_t head;
    logic              space_ok;

    trle_encode #(
        .MAX_LEN (MAX_LEN)
    ) u_encode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .space_ok    (space_ok),
        .push        (push)
    );

    trle_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the head result onto the output beat; the totals are zero except on
    // the flushed run that closes a vector.
    assign m_tdata = {6'b000000, head.runs_total, head.kept_total, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.eov;

endmodule
